// ----- design/shc_pkg.sv -----
`default_nettype none

package shc_pkg;

    // One input beat: a raw header byte and its framing flags.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_header;
        logic       end_of_buffer;
    } hdr_beat_t;

    // One result beat: the check outcome and every decoded field.
    typedef struct packed {
        logic [2:0]  status;
        logic [4:0]  error_offset;
        logic [15:0] version_number;
        logic [15:0] page_bytes;
        logic [31:0] page_total;
        logic [31:0] root_index;
        logic [31:0] strtab_index;
        logic [31:0] journal_position;
        logic [31:0] flag_bits;
        logic [31:0] stored_crc;
        logic        crc_match;
    } hdr_result_t;

    // Configuration register file as seen by the checking logic.
    typedef struct packed {
        logic [15:0] supported_version;
        logic        strict_mode;
        logic [15:0] min_page_size;
        logic [15:0] max_page_size;
    } hdr_cfg_t;

    // Status codes.
    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_BAD_MAGIC    = 3'd1;
    localparam logic [2:0] ST_BAD_VERSION  = 3'd2;
    localparam logic [2:0] ST_BAD_LENGTH   = 3'd3;
    localparam logic [2:0] ST_BAD_CHECKSUM = 3'd4;
    localparam logic [2:0] ST_TRUNCATED    = 3'd5;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SUPPORTED_VERSION = 2'd0;
    localparam logic [1:0] CFG_STRICT_MODE       = 2'd1;
    localparam logic [1:0] CFG_MIN_PAGE_SIZE     = 2'd2;
    localparam logic [1:0] CFG_MAX_PAGE_SIZE     = 2'd3;

    // Configuration reset values.
    localparam logic [15:0] RST_SUPPORTED_VERSION = 16'd1;
    localparam logic        RST_STRICT_MODE       = 1'b0;
    localparam logic [15:0] RST_MIN_PAGE_SIZE     = 16'd64;
    localparam logic [15:0] RST_MAX_PAGE_SIZE     = 16'd8192;

    // Header byte offsets.
    localparam logic [4:0] OFS_MAGIC        = 5'd0;
    localparam logic [4:0] OFS_VERSION      = 5'd4;
    localparam logic [4:0] OFS_VERSION_HI   = 5'd5;
    localparam logic [4:0] OFS_PAGE_SIZE    = 5'd6;
    localparam logic [4:0] OFS_PAGE_SIZE_HI = 5'd7;
    localparam logic [4:0] OFS_CHECKSUM     = 5'd28;
    localparam logic [4:0] OFS_LAST         = 5'd31;

    // Number of 32-bit words after the two 16-bit fields.
    localparam int unsigned NUM_WORDS = 6;

    // Magic bytes, offset 0 in the low lane.
    localparam logic [3:0][7:0] HDR_MAGIC = {8'h31, 8'h42, 8'h44, 8'h4D};

    // Page size alignment; must be a power of two.
    localparam int unsigned  PAGE_ALIGN = 16;
    localparam logic [15:0]  ALIGN_MASK = 16'(PAGE_ALIGN - 1);

    // Reflected CRC-32.
    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- design/shc_in_stage.sv -----
`default_nettype none

module shc_in_stage (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire shc_pkg::hdr_beat_t s_data,
    output logic                   beat_valid,
    input  wire logic              beat_ready,
    output shc_pkg::hdr_beat_t     beat
);
    import shc_pkg::*;

    logic      valid_reg;
    hdr_beat_t beat_reg;

    // The register refills in the same cycle that the core consumes it.
    assign s_ready    = !valid_reg || beat_ready;
    assign beat_valid = valid_reg;
    assign beat       = beat_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            beat_reg <= s_data;
        end
    end

endmodule

`default_nettype wire

// ----- design/shc_hdr_core.sv -----
`default_nettype none

module shc_hdr_core (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire shc_pkg::hdr_cfg_t   cfg,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire shc_pkg::hdr_beat_t  in_beat,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output shc_pkg::hdr_result_t     m_data
);
    import shc_pkg::*;

    logic        active_reg;
    logic [4:0]  pos_reg;
    logic [31:0] crc_reg;
    logic [2:0]  err_reg;
    logic [4:0]  err_pos_reg;
    logic [15:0] ver_reg;
    logic [15:0] page_reg;
    logic [31:0] words_reg [NUM_WORDS];
    logic        out_valid_reg;
    hdr_result_t out_reg;

    logic        fire;
    logic        sof;
    logic        act;
    logic        last;
    logic        emit;
    logic        match;
    logic [7:0]  b;
    logic [4:0]  pos_cur;
    logic [31:0] crc_cur;
    logic [2:0]  err_cur;
    logic [4:0]  err_pos_cur;
    logic [4:0]  pos_next;
    logic [31:0] crc_next;
    logic [2:0]  err_next;
    logic [4:0]  err_pos_next;
    logic [15:0] ver_next;
    logic [15:0] page_next;
    logic [31:0] words_next [NUM_WORDS];
    logic        page_bad;
    hdr_result_t result_next;

    assign in_ready = !out_valid_reg || m_ready;
    assign fire     = in_valid && in_ready;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_reg;

    always_comb begin
        b   = in_beat.data_byte;
        sof = in_beat.start_of_header;
        act = active_reg || sof;

        // A start byte begins from a clean header.
        pos_cur     = sof ? OFS_MAGIC : pos_reg;
        crc_cur     = sof ? CRC_INIT : crc_reg;
        err_cur     = sof ? ST_OK : err_reg;
        err_pos_cur = sof ? OFS_MAGIC : err_pos_reg;
        ver_next    = sof ? 16'd0 : ver_reg;
        page_next   = sof ? 16'd0 : page_reg;
        for (int i = 0; i < NUM_WORDS; i++) begin
            words_next[i] = sof ? 32'd0 : words_reg[i];
        end

        crc_next = (pos_cur < OFS_CHECKSUM) ? crc32_byte(crc_cur, b) : crc_cur;

        if (pos_cur == OFS_VERSION) begin
            ver_next[7:0] = b;
        end
        if (pos_cur == OFS_VERSION_HI) begin
            ver_next[15:8] = b;
        end
        if (pos_cur == OFS_PAGE_SIZE) begin
            page_next[7:0] = b;
        end
        if (pos_cur == OFS_PAGE_SIZE_HI) begin
            page_next[15:8] = b;
        end
        for (int i = 0; i < NUM_WORDS; i++) begin
            if (pos_cur[4:2] == 3'(i + 2)) begin
                words_next[i][{pos_cur[1:0], 3'b000} +: 8] = b;
            end
        end

        page_bad = (page_next < cfg.min_page_size) || (page_next > cfg.max_page_size)
                   || ((page_next & ALIGN_MASK) != 16'd0);

        err_next     = err_cur;
        err_pos_next = err_pos_cur;
        if (err_cur == ST_OK) begin
            if (pos_cur[4:2] == 3'd0 && b != HDR_MAGIC[pos_cur[1:0]]) begin
                err_next     = ST_BAD_MAGIC;
                err_pos_next = OFS_MAGIC;
            end else if (pos_cur == OFS_VERSION_HI && ver_next != cfg.supported_version) begin
                err_next     = ST_BAD_VERSION;
                err_pos_next = OFS_VERSION;
            end else if (pos_cur == OFS_PAGE_SIZE_HI && page_bad) begin
                err_next     = ST_BAD_LENGTH;
                err_pos_next = OFS_PAGE_SIZE;
            end
        end

        last  = (pos_cur == OFS_LAST);
        match = ((crc_next ^ CRC_INIT) == words_next[NUM_WORDS-1]);
        if (last && !match && cfg.strict_mode && err_next == ST_OK) begin
            err_next     = ST_BAD_CHECKSUM;
            err_pos_next = OFS_CHECKSUM;
        end

        emit     = act && (last || in_beat.end_of_buffer);
        pos_next = emit ? OFS_MAGIC : pos_cur + 5'd1;

        result_next.status           = last ? err_next : ST_TRUNCATED;
        result_next.error_offset     = last ? err_pos_next : OFS_MAGIC;
        result_next.version_number   = ver_next;
        result_next.page_bytes       = page_next;
        result_next.page_total       = words_next[0];
        result_next.root_index       = words_next[1];
        result_next.strtab_index     = words_next[2];
        result_next.journal_position = words_next[3];
        result_next.flag_bits        = words_next[4];
        result_next.stored_crc       = words_next[5];
        result_next.crc_match        = last && match;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg    <= 1'b0;
            pos_reg       <= OFS_MAGIC;
            crc_reg       <= CRC_INIT;
            err_reg       <= ST_OK;
            err_pos_reg   <= OFS_MAGIC;
            out_valid_reg <= 1'b0;
        end else begin
            if (fire && act) begin
                active_reg  <= !emit;
                pos_reg     <= pos_next;
                crc_reg     <= crc_next;
                err_reg     <= err_next;
                err_pos_reg <= err_pos_next;
            end
            if (fire && emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && act) begin
            ver_reg  <= ver_next;
            page_reg <= page_next;
            for (int i = 0; i < NUM_WORDS; i++) begin
                words_reg[i] <= words_next[i];
            end
        end
        if (fire && emit) begin
            out_reg <= result_next;
        end
    end

    // Outside a header the offset counter rests at zero.
    a_idle_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        !active_reg |-> pos_reg == OFS_MAGIC)
        else $error("offset counter not at zero while idle");

    // No error recorded means no error offset recorded.
    a_err_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        err_reg == ST_OK |-> err_pos_reg == OFS_MAGIC)
        else $error("error offset set without an error");

    // A truncated result never reports an offset or a matching CRC.
    a_trunc: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg.status == ST_TRUNCATED
        |-> out_reg.error_offset == OFS_MAGIC && !out_reg.crc_match)
        else $error("truncated result carries offset or CRC match");

    // A new result only appears after a processed beat.
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(fire))
        else $error("result appeared without a processed beat");

endmodule

`default_nettype wire

// ----- design/store_header_checker_top.sv -----
`default_nettype none

// Data path: a byte beat is accepted into the input register and decoded by the core from
// there; the result register is loaded when the core takes the final byte of a header.
// Throughput: one byte beat per cycle; only a result beat left waiting on m_ready stalls
// the input. The CRC update and field assembly fit between the input and result registers.
// Reset: aresetn is synchronous and active low; it clears the handshake and header
// state and restores the configuration registers to their defaults. No clearing pass.

module store_header_checker_top (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // Header byte stream.
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire shc_pkg::hdr_beat_t   s_data,
    // Check results.
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output shc_pkg::hdr_result_t      m_data,
    // Configuration writes.
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [15:0]          cfg_data
);
    import shc_pkg::*;

    hdr_cfg_t  cfg_reg;
    logic      beat_valid;
    logic      beat_ready;
    hdr_beat_t beat;

    // Configuration writes are always taken. They are expected only while no header
    // is in flight, so every check sees a stable register value.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.supported_version <= RST_SUPPORTED_VERSION;
            cfg_reg.strict_mode       <= RST_STRICT_MODE;
            cfg_reg.min_page_size     <= RST_MIN_PAGE_SIZE;
            cfg_reg.max_page_size     <= RST_MAX_PAGE_SIZE;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_SUPPORTED_VERSION: begin
                    cfg_reg.supported_version <= cfg_data;
                end
                CFG_STRICT_MODE: begin
                    cfg_reg.strict_mode <= cfg_data[0];
                end
                CFG_MIN_PAGE_SIZE: begin
                    cfg_reg.min_page_size <= cfg_data;
                end
                CFG_MAX_PAGE_SIZE: begin
                    cfg_reg.max_page_size <= cfg_data;
                end
                default: begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    // The input register takes a new beat whenever the core consumes the held one,
    // so the stream runs at one beat per cycle while the result side keeps up.
    shc_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .beat_valid (beat_valid),
        .beat_ready (beat_ready),
        .beat       (beat)
    );

    // The core tracks the header offset, updates the CRC, assembles the fields,
    // records the first error and loads one result beat per header that a new start does not abandon.
    shc_hdr_core u_hdr_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .in_valid (beat_valid),
        .in_ready (beat_ready),
        .in_beat  (beat),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
`default_nettype none

// Checks the store header checker with header byte streams.
// A driver sends byte beats from a queue and a monitor samples both channels
// at the rising edge. For every byte beat taken, the monitor runs a
// cycle-free model of the header decoder and keeps the verdict it predicts.
// Each result beat from the block is then compared, field by field, with the
// oldest predicted verdict.
module testbench;
    import shc_pkg::*;

    // Clock, reset and the block's inputs. Every input has a known value from
    // time zero on.
    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    hdr_beat_t   s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    hdr_result_t m_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_SUPPORTED_VERSION;
    logic [15:0] cfg_data = '0;

    store_header_checker_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Byte beats waiting to be sent. Each one carries the number of idle
    // cycles that the driver leaves before offering it.
    hdr_beat_t   byte_queue[$];
    int          gap_queue[$];
    int          beats_sent = 0;
    int          beats_taken = 0;

    // Result side bookkeeping.
    hdr_result_t predicted_verdicts[$];
    int          results_taken = 0;
    int          results_seen = 0;
    int          stall_left = 0;
    bit          rx_stall_on = 1'b1;
    int          mismatches = 0;

    // The model's copy of the registers.
    logic [15:0] lim_version;
    logic        lim_strict;
    logic [15:0] lim_min_page;
    logic [15:0] lim_max_page;

    // The model's header state.
    logic [4:0]      hdr_ofs;
    logic            hdr_active;
    logic [31:0]     hdr_crc;
    logic [2:0]      hdr_error;
    logic [4:0]      hdr_error_ofs;
    logic [3:0][7:0] hdr_words [7];
    logic [1:0][7:0] hdr_shorts [2];

    // Reflected CRC-32, one data bit at a time from the least significant one.
    function automatic logic [31:0] crc_update(input logic [31:0] crc, input logic [7:0] b);
        logic feedback;
        for (int i = 0; i < 8; i++) begin
            feedback = crc[0] ^ b[i];
            crc = crc >> 1;
            if (feedback)
                crc = crc ^ CRC_POLY;
        end
        return crc;
    endfunction

    function automatic void clear_header_state();
        hdr_ofs = '0;
        hdr_crc = CRC_INIT;
        hdr_error = ST_OK;
        hdr_error_ofs = '0;
        for (int i = 0; i < 7; i++)
            hdr_words[i] = '0;
        hdr_shorts[0] = '0;
        hdr_shorts[1] = '0;
    endfunction

    // Only the first error of a header is kept.
    function automatic void note_error(input logic [2:0] code, input logic [4:0] ofs);
        if (hdr_error == ST_OK) begin
            hdr_error = code;
            hdr_error_ofs = ofs;
        end
    endfunction

    // Advances the header model by one byte beat. Returns 1 when the beat
    // closes a header, with the verdict in res.
    function automatic bit decode_header_byte(input hdr_beat_t beat, output hdr_result_t res);
        logic [4:0] ofs;
        logic       match;
        res = '0;
        match = 1'b0;
        if (beat.start_of_header) begin
            clear_header_state();
            hdr_active = 1'b1;
        end
        if (!hdr_active)
            return 1'b0;
        ofs = hdr_ofs;
        if (ofs < OFS_CHECKSUM)
            hdr_crc = crc_update(hdr_crc, beat.data_byte);
        if (ofs < OFS_VERSION) begin
            hdr_words[0][ofs[1:0]] = beat.data_byte;
            if (beat.data_byte != HDR_MAGIC[ofs[1:0]])
                note_error(ST_BAD_MAGIC, OFS_MAGIC);
        end else if (ofs < 5'd8) begin
            hdr_shorts[ofs[1]][ofs[0]] = beat.data_byte;
            if (ofs == OFS_VERSION_HI && hdr_shorts[0] != lim_version)
                note_error(ST_BAD_VERSION, OFS_VERSION);
            if (ofs == OFS_PAGE_SIZE_HI && (hdr_shorts[1] < lim_min_page ||
                    hdr_shorts[1] > lim_max_page || (hdr_shorts[1] % PAGE_ALIGN) != 0))
                note_error(ST_BAD_LENGTH, OFS_PAGE_SIZE);
        end else begin
            hdr_words[int'(ofs[4:2]) - 1][ofs[1:0]] = beat.data_byte;
        end

        if (ofs == OFS_LAST) begin
            match = (~hdr_crc == hdr_words[6]);
            if (!match && lim_strict)
                note_error(ST_BAD_CHECKSUM, OFS_CHECKSUM);
            res.status = hdr_error;
            res.error_offset = hdr_error_ofs;
        end else if (beat.end_of_buffer) begin
            // A short buffer wins over whatever was found so far.
            res.status = ST_TRUNCATED;
            res.error_offset = '0;
        end else begin
            hdr_ofs = ofs + 5'd1;
            return 1'b0;
        end
        res.version_number = hdr_shorts[0];
        res.page_bytes = hdr_shorts[1];
        res.page_total = hdr_words[1];
        res.root_index = hdr_words[2];
        res.strtab_index = hdr_words[3];
        res.journal_position = hdr_words[4];
        res.flag_bits = hdr_words[5];
        res.stored_crc = hdr_words[6];
        res.crc_match = match;
        hdr_active = 1'b0;
        hdr_ofs = '0;
        return 1'b1;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    // Monitor. Everything is sampled at the rising edge, before the block's
    // own outputs move, so each handshake is seen exactly as the block saw it.
    always @(posedge aclk) begin
        hdr_result_t verdict;
        if (!aresetn) begin
            lim_version = RST_SUPPORTED_VERSION;
            lim_strict = RST_STRICT_MODE;
            lim_min_page = RST_MIN_PAGE_SIZE;
            lim_max_page = RST_MAX_PAGE_SIZE;
            hdr_active = 1'b0;
            clear_header_state();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_SUPPORTED_VERSION: lim_version = cfg_data;
                    CFG_STRICT_MODE:       lim_strict = cfg_data[0];
                    CFG_MIN_PAGE_SIZE:     lim_min_page = cfg_data;
                    CFG_MAX_PAGE_SIZE:     lim_max_page = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                beats_taken++;
                if (decode_header_byte(s_data, verdict))
                    predicted_verdicts.push_back(verdict);
            end
            if (m_valid && m_ready) begin
                results_taken++;
                if (predicted_verdicts.size() == 0) begin
                    $error("result beat arrived while no verdict was predicted");
                    mismatches++;
                end else begin
                    verdict = predicted_verdicts.pop_front();
                    check_field("status", verdict.status, m_data.status);
                    check_field("error_offset", verdict.error_offset, m_data.error_offset);
                    check_field("version_number", verdict.version_number,
                                m_data.version_number);
                    check_field("page_bytes", verdict.page_bytes, m_data.page_bytes);
                    check_field("page_total", verdict.page_total, m_data.page_total);
                    check_field("root_index", verdict.root_index, m_data.root_index);
                    check_field("strtab_index", verdict.strtab_index, m_data.strtab_index);
                    check_field("journal_position", verdict.journal_position,
                                m_data.journal_position);
                    check_field("flag_bits", verdict.flag_bits, m_data.flag_bits);
                    check_field("stored_crc", verdict.stored_crc, m_data.stored_crc);
                    check_field("crc_match", verdict.crc_match, m_data.crc_match);
                end
            end
        end
    end

    // Driver. A beat on offer is held until the monitor has counted it as
    // taken; only then may the next one go out, after its idle cycles. There
    // is a single assignment to s_valid per falling edge, so back-to-back beats
    // keep valid high.
    always @(negedge aclk) begin
        if (aresetn && !(s_valid && beats_taken != beats_sent)) begin
            if (byte_queue.size() == 0) begin
                s_valid <= 1'b0;
            end else if (gap_queue[0] != 0) begin
                gap_queue[0] = gap_queue[0] - 1;
                s_valid <= 1'b0;
            end else begin
                s_data <= byte_queue.pop_front();
                void'(gap_queue.pop_front());
                beats_sent++;
                s_valid <= 1'b1;
            end
        end
    end

    // Result receiver. A fresh stall is drawn for every result beat, and it
    // only runs down while a result is actually waiting, so the block sees
    // back-pressure at every point of its output handshake.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (results_seen != results_taken) begin
                results_seen = results_taken;
                stall_left = rx_stall_on ? int'($urandom_range(0, 11)) : 0;
            end
            if (stall_left != 0) begin
                m_ready <= 1'b0;
                if (m_valid)
                    stall_left--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    function automatic void queue_beat(input logic [7:0] b, input bit sof, input bit eob,
                                       input bit gaps_on);
        hdr_beat_t beat;
        beat.data_byte = b;
        beat.start_of_header = sof;
        beat.end_of_buffer = eob;
        byte_queue.push_back(beat);
        gap_queue.push_back(gaps_on ? int'($urandom_range(0, 11)) : 0);
    endfunction

    // Queues one header built for the current register values, mostly well
    // formed, sometimes with broken fields, cut short or abandoned by the next
    // start. Returns the number of header bytes it queued.
    function automatic int queue_header();
        logic [7:0]  img [32];
        logic [31:0] crc;
        logic [31:0] word;
        logic [15:0] ps;
        int          lo;
        int          hi;
        int          idx;
        int          flaws;
        int          form;
        int          len;
        bit          gaps_on;
        bit          end_flag;

        gaps_on = ($urandom_range(0, 2) != 0);
        for (int i = 0; i < 4; i++)
            img[i] = HDR_MAGIC[i];
        img[4] = lim_version[7:0];
        img[5] = lim_version[15:8];

        // Pick a legal page size if the limits leave one, else anything.
        lo = (int'(lim_min_page) + PAGE_ALIGN - 1) / PAGE_ALIGN * PAGE_ALIGN;
        hi = int'(lim_max_page) / PAGE_ALIGN * PAGE_ALIGN;
        if (lo > hi) begin
            ps = 16'($urandom);
        end else begin
            case ($urandom_range(0, 3))
                0: ps = 16'(lo);
                1: ps = 16'(hi);
                default: ps = 16'(lo + PAGE_ALIGN * $urandom_range(0, (hi - lo) / PAGE_ALIGN));
            endcase
        end
        img[6] = ps[7:0];
        img[7] = ps[15:8];

        for (int w = 0; w < 5; w++) begin
            case ($urandom_range(0, 7))
                0: word = '0;
                1: word = '1;
                default: word = $urandom;
            endcase
            for (int k = 0; k < 4; k++)
                img[8 + 4 * w + k] = word[8 * k +: 8];
        end

        // Flaws: bit 0 magic, bit 1 version, bit 2 page size, bit 3 checksum,
        // bit 4 random bytes anywhere.
        case ($urandom_range(0, 9))
            0, 1, 2, 3: flaws = 0;
            4: flaws = $urandom_range(1, 31);
            default: flaws = 1 << $urandom_range(0, 4);
        endcase
        if (flaws[0]) begin
            idx = $urandom_range(0, 3);
            img[idx] = img[idx] ^ 8'($urandom_range(1, 255));
        end
        if (flaws[1]) begin
            idx = 4 + $urandom_range(0, 1);
            img[idx] = img[idx] ^ 8'($urandom_range(1, 255));
        end
        if (flaws[2]) begin
            case ($urandom_range(0, 2))
                0: ps = lim_min_page - 16'd1;
                1: ps = lim_max_page + 16'd1;
                default: ps = ps ^ 16'($urandom_range(1, PAGE_ALIGN - 1));
            endcase
            img[6] = ps[7:0];
            img[7] = ps[15:8];
        end

        crc = CRC_INIT;
        for (int i = 0; i < 28; i++)
            crc = crc_update(crc, img[i]);
        crc = ~crc;
        if (flaws[3])
            crc = crc ^ (32'd1 << $urandom_range(0, 31));
        for (int k = 0; k < 4; k++)
            img[28 + k] = crc[8 * k +: 8];
        if (flaws[4]) begin
            repeat ($urandom_range(1, 4)) begin
                idx = $urandom_range(0, 31);
                img[idx] = 8'($urandom);
            end
        end

        // Framing: complete, cut short by the end of the buffer, or left
        // unfinished so that the next start abandons it.
        form = $urandom_range(0, 19);
        if (form < 13) begin
            len = 32;
            end_flag = 1'($urandom_range(0, 1));
        end else if (form < 17) begin
            len = (form == 13) ? 31 : int'($urandom_range(1, 31));
            end_flag = 1'b1;
        end else begin
            len = $urandom_range(1, 31);
            end_flag = 1'b0;
        end
        for (int i = 0; i < len; i++)
            queue_beat(img[i], i == 0, end_flag && i == len - 1, gaps_on);

        // Bytes past the end of a header must be ignored, end flag or not.
        if (form < 17) begin
            repeat ($urandom_range(0, 2))
                queue_beat(8'($urandom), 1'b0, 1'($urandom_range(0, 1)), gaps_on);
        end
        return len;
    endfunction

    // Waits until every queued beat is taken and every predicted verdict has
    // come back, then lets the clock run on so that beats which give no result
    // have left the block too.
    task automatic drain_pipeline();
        while (byte_queue.size() != 0 || beats_sent != beats_taken ||
               predicted_verdicts.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_register(input logic [1:0] index, input logic [15:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic program_limits(input logic [15:0] version, input logic strict,
                                  input logic [15:0] min_page, input logic [15:0] max_page);
        write_register(CFG_SUPPORTED_VERSION, version);
        write_register(CFG_STRICT_MODE, {15'd0, strict});
        write_register(CFG_MIN_PAGE_SIZE, min_page);
        write_register(CFG_MAX_PAGE_SIZE, max_page);
    endtask

    initial begin
        int queued;

        // Directed beats, checked against the reset register values.
        // Idle bytes before any start are ignored, end flag included.
        queue_beat(8'h00, 1'b0, 1'b1, 1'b1);
        queue_beat(8'hFF, 1'b0, 1'b0, 1'b1);
        // A one-byte buffer is reported as truncated even though its magic
        // byte is wrong as well.
        queue_beat(8'hFF, 1'b1, 1'b1, 1'b1);
        // Two magic bytes, then a new start abandons them without a result.
        queue_beat(HDR_MAGIC[0], 1'b1, 1'b0, 1'b1);
        queue_beat(HDR_MAGIC[1], 1'b0, 1'b0, 1'b1);
        // A fresh header that ends on the page size high byte: the partly
        // received fields come back with the truncated status.
        for (int i = 0; i < 4; i++)
            queue_beat(HDR_MAGIC[i], i == 0, 1'b0, 1'b0);
        queue_beat(8'h01, 1'b0, 1'b0, 1'b0);
        queue_beat(8'h00, 1'b0, 1'b0, 1'b0);
        queue_beat(8'h40, 1'b0, 1'b0, 1'b0);
        queue_beat(8'h00, 1'b0, 1'b1, 1'b0);
        // Another stray byte after the end, then a two-byte buffer.
        queue_beat(8'h00, 1'b0, 1'b1, 1'b1);
        queue_beat(8'h00, 1'b1, 1'b0, 1'b1);
        queue_beat(8'hFF, 1'b0, 1'b1, 1'b1);

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        drain_pipeline();

        // Random headers under several register settings. The sender stops
        // between settings until every verdict is back, so that the registers
        // only change while the block is quiet.
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: program_limits(16'd1, 1'b1, 16'd64, 16'd8192);
                1: program_limits(16'd0, 1'b0, 16'd0, 16'hFFFF);
                2: program_limits(16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF);
                3: program_limits(16'($urandom), 1'b0, 16'd16, 16'd16);
                4: program_limits(16'($urandom), 1'b1, 16'd4096, 16'd0);
                default: program_limits(16'($urandom), 1'($urandom_range(0, 1)),
                                        16'($urandom_range(0, 512)),
                                        16'($urandom_range(256, 16384)));
            endcase
            rx_stall_on = (phase % 3 != 2);
            queued = 0;
            while (queued < 172)
                queued += queue_header();
            // A last one-byte buffer closes any header left unfinished.
            queue_beat(8'h00, 1'b1, 1'b1, 1'b0);
            drain_pipeline();
        end

        if (mismatches == 0 && predicted_verdicts.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog far beyond the slowest legal run.
    initial begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
